FILE: sv/rpwc_pkg.sv
`timescale 1ns / 1ps

package rpwc_pkg;

	localparam int NUM_CHANNELS_DEFAULT = 6;

	localparam int TIME_W  = 32;
	localparam int GAP_W   = 20;
	localparam int WIDTH_W = 16;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAP_MIN   = 2'd0,
		REG_GAP_MAX   = 2'd1,
		REG_WIDTH_MIN = 2'd2,
		REG_WIDTH_MAX = 2'd3
	} cfg_reg_t;

	localparam logic [GAP_W-1:0]   GAP_MIN_RESET   = 20'd10000;
	localparam logic [GAP_W-1:0]   GAP_MAX_RESET   = 20'd26000;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN_RESET = 16'd800;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX_RESET = 16'd2200;

endpackage

FILE: sv/rpwc_event_if.sv
`timescale 1ns / 1ps

interface rpwc_event_if #(
	parameter int NUM_CHANNELS = rpwc_pkg::NUM_CHANNELS_DEFAULT
);
	logic                        valid;
	logic                        ready;
	logic [NUM_CHANNELS-1:0]     pin_levels;
	logic [rpwc_pkg::TIME_W-1:0] timestamp_us;

	modport source (output valid, output pin_levels, output timestamp_us, input ready);
	modport sink (input valid, input pin_levels, input timestamp_us, output ready);
endinterface

FILE: sv/rpwc_pulse_if.sv
`timescale 1ns / 1ps

interface rpwc_pulse_if #(
	parameter int CH_W = 3
);
	logic                         valid;
	logic                         ready;
	logic [CH_W-1:0]              channel;
	logic [rpwc_pkg::WIDTH_W-1:0] pulse_width_us;
	logic                         last;

	modport source (output valid, output channel, output pulse_width_us, output last,
		input ready);
	modport sink (input valid, input channel, input pulse_width_us, input last,
		output ready);
endinterface

FILE: sv/rc_pulse_width_capture.sv
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// events    sink       pin_levels, timestamp_us of one pin-change event
// pulses    source     channel, pulse_width_us, last of one good pulse
// cfg       write      cfg_we, cfg_index, cfg_wdata (no read-back)
//
// An event is accepted in ST_IDLE, then passes one channel at a time through the
// shared subtract-and-window-compare unit in ST_SCAN, and ST_FLUSH releases the held result, if any.
// The scan and the flush wait only while the output register is still occupied.
// arst_n clears levels, stamps, arm flags and loads the default windows.
// The newest result is held back one step so that last can be set on it.

module rc_pulse_width_capture #(
	parameter int NUM_CHANNELS = rpwc_pkg::NUM_CHANNELS_DEFAULT,
	parameter int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rpwc_event_if.sink                     events,
	rpwc_pulse_if.source                   pulses,
	input  logic                           cfg_we,
	input  logic [rpwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpwc_pkg::CFG_W-1:0]     cfg_wdata
);
	import rpwc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	state_t state_q;

	logic [GAP_W-1:0]   gap_min_q;
	logic [GAP_W-1:0]   gap_max_q;
	logic [WIDTH_W-1:0] width_min_q;
	logic [WIDTH_W-1:0] width_max_q;

	logic [NUM_CHANNELS-1:0] prev_levels_q;
	logic [NUM_CHANNELS-1:0] levels_q;
	logic [NUM_CHANNELS-1:0] changed_q;
	logic [TIME_W-1:0]       now_q;
	logic [TIME_W-1:0]       rise_q [NUM_CHANNELS];
	logic [TIME_W-1:0]       fall_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] armed_q;
	logic [CH_W-1:0]         ch_q;

	logic               pend_valid_q;
	logic [CH_W-1:0]    pend_ch_q;
	logic [WIDTH_W-1:0] pend_width_q;

	logic               out_valid_q;
	logic [CH_W-1:0]    out_ch_q;
	logic [WIDTH_W-1:0] out_width_q;
	logic               out_last_q;

	// Shared unit: one wrapped subtraction and a window compare per cycle, held while the scan stalls.
	logic              rising;
	logic [TIME_W-1:0] stamp;
	logic [TIME_W-1:0] win_lo;
	logic [TIME_W-1:0] win_hi;
	logic [TIME_W-1:0] span;
	logic              in_window;
	logic              hit;
	logic              slot_free;
	logic              ch_stall;

	always_comb begin
		rising = levels_q[ch_q];
		if (rising) begin
			stamp  = fall_q[ch_q];
			win_lo = TIME_W'(gap_min_q);
			win_hi = TIME_W'(gap_max_q);
		end else begin
			stamp  = rise_q[ch_q];
			win_lo = TIME_W'(width_min_q);
			win_hi = TIME_W'(width_max_q);
		end
		span      = now_q - stamp;
		in_window = (span >= win_lo) && (span <= win_hi);
		hit       = changed_q[ch_q] && !rising && armed_q[ch_q] && in_window;
		slot_free = !out_valid_q || pulses.ready;
		ch_stall  = hit && pend_valid_q && !slot_free;
	end

	assign events.ready          = (state_q == ST_IDLE);
	assign pulses.valid          = out_valid_q;
	assign pulses.channel        = out_ch_q;
	assign pulses.pulse_width_us = out_width_q;
	assign pulses.last           = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_min_q   <= GAP_MIN_RESET;
			gap_max_q   <= GAP_MAX_RESET;
			width_min_q <= WIDTH_MIN_RESET;
			width_max_q <= WIDTH_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAP_MIN:   gap_min_q   <= cfg_wdata[GAP_W-1:0];
				REG_GAP_MAX:   gap_max_q   <= cfg_wdata[GAP_W-1:0];
				REG_WIDTH_MIN: width_min_q <= cfg_wdata[WIDTH_W-1:0];
				REG_WIDTH_MAX: width_max_q <= cfg_wdata[WIDTH_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_levels_q <= '0;
			levels_q      <= '0;
			changed_q     <= '0;
			now_q         <= '0;
			armed_q       <= '0;
			ch_q          <= '0;
			pend_valid_q  <= 1'b0;
			pend_ch_q     <= '0;
			pend_width_q  <= '0;
			out_valid_q   <= 1'b0;
			out_ch_q      <= '0;
			out_width_q   <= '0;
			out_last_q    <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				rise_q[i] <= '0;
				fall_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && pulses.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (events.valid) begin
						levels_q      <= events.pin_levels;
						changed_q     <= events.pin_levels ^ prev_levels_q;
						prev_levels_q <= events.pin_levels;
						now_q         <= events.timestamp_us;
						ch_q          <= '0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!ch_stall) begin
						if (changed_q[ch_q]) begin
							if (rising) begin
								rise_q[ch_q]  <= now_q;
								armed_q[ch_q] <= in_window;
							end else begin
								fall_q[ch_q] <= now_q;
							end
						end
						if (hit) begin
							armed_q[ch_q] <= 1'b0;
							// A newer result exists, so the held one is not the last.
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_ch_q    <= pend_ch_q;
								out_width_q <= pend_width_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_ch_q    <= ch_q;
							pend_width_q <= span[WIDTH_W-1:0];
						end
						if (ch_q == LAST_CH) begin
							state_q <= ST_FLUSH;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_ch_q     <= pend_ch_q;
						out_width_q  <= pend_width_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import rpwc_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEFAULT;
	localparam int SETTLE_CYC   = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SHOW_ERRS    = 10;

	typedef struct {
		logic [2:0]         channel;
		logic [WIDTH_W-1:0] width;
		logic               last;
	} pulse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	rpwc_event_if #(.NUM_CHANNELS(NCH)) ev();
	rpwc_pulse_if #(.CH_W(3)) pu();

	rc_pulse_width_capture #(.NUM_CHANNELS(NCH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.events(ev),
		.pulses(pu),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Capture model state, kept in step with every accepted transaction.
	logic [NCH-1:0]     prev_levels;
	logic [TIME_W-1:0]  rise_at [NCH];
	logic [TIME_W-1:0]  fall_at [NCH];
	logic               is_armed [NCH];
	logic [GAP_W-1:0]   gap_lo, gap_hi;
	logic [WIDTH_W-1:0] wid_lo, wid_hi;

	pulse_t pending_pulses[$];
	logic [TIME_W-1:0] now_us;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int events_sent = 0;
	int pulses_seen = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;

	function automatic void capture_events(input logic [NCH-1:0] lv, input logic [TIME_W-1:0] t);
		logic [NCH-1:0] changed;
		logic [TIME_W-1:0] span;
		pulse_t p;
		int n;
		changed = lv ^ prev_levels;
		prev_levels = lv;
		n = 0;
		for (int k = 0; k < NCH; k++) begin
			if (changed[k]) begin
				if (lv[k]) begin
					span = t - fall_at[k];
					rise_at[k] = t;
					is_armed[k] = (span >= gap_lo) && (span <= gap_hi);
				end else begin
					span = t - rise_at[k];
					fall_at[k] = t;
					if (is_armed[k] && span >= wid_lo && span <= wid_hi) begin
						is_armed[k] = 1'b0;
						p.channel = k[2:0];
						p.width = span[WIDTH_W-1:0];
						p.last = 1'b0;
						pending_pulses.push_back(p);
						n++;
					end
				end
			end
		end
		if (n > 0)
			pending_pulses[pending_pulses.size()-1].last = 1'b1;
	endfunction

	function automatic void note_error(input string msg);
		err_cnt++;
		if (err_cnt <= SHOW_ERRS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	// Receiver side: random back-pressure and result checking.
	always @(negedge clk) begin
		pu.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		pulse_t exp_p;
		if (pu.valid && pu.ready) begin
			pulses_seen++;
			if (pending_pulses.size() == 0) begin
				note_error($sformatf("unexpected pulse ch=%0d width=%0d last=%0b",
					pu.channel, pu.pulse_width_us, pu.last));
			end else begin
				exp_p = pending_pulses.pop_front();
				if (pu.channel !== exp_p.channel || pu.pulse_width_us !== exp_p.width ||
						pu.last !== exp_p.last)
					note_error($sformatf({"pulse expected ch=%0d width=%0d last=%0b, ",
						"got ch=%0d width=%0d last=%0b"},
						exp_p.channel, exp_p.width, exp_p.last,
						pu.channel, pu.pulse_width_us, pu.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction,
	// with valid still high so that back-to-back items need no second assignment.
	task automatic send_event(input logic [NCH-1:0] lv, input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < src_idle_pct) begin
			ev.valid <= 1'b0;
			@(negedge clk);
		end
		ev.valid <= 1'b1;
		ev.pin_levels <= lv;
		ev.timestamp_us <= t;
		do
			@(posedge clk);
		while (!ev.ready);
		capture_events(lv, t);
		events_sent++;
		now_us = t;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		ev.valid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_GAP_MIN:   gap_lo = data[GAP_W-1:0];
			REG_GAP_MAX:   gap_hi = data[GAP_W-1:0];
			REG_WIDTH_MIN: wid_lo = data[WIDTH_W-1:0];
			REG_WIDTH_MAX: wid_hi = data[WIDTH_W-1:0];
		endcase
		@(negedge clk);
	endtask

	task automatic set_windows(input logic [CFG_W-1:0] g_lo, g_hi, w_lo, w_hi);
		wait_idle();
		write_reg(REG_GAP_MIN, g_lo);
		write_reg(REG_GAP_MAX, g_hi);
		write_reg(REG_WIDTH_MIN, w_lo);
		write_reg(REG_WIDTH_MAX, w_hi);
		cfg_we <= 1'b0;
	endtask

	// Mostly inside the window, with the bounds and one step past them often.
	function automatic logic [TIME_W-1:0] pick_near(input logic [TIME_W-1:0] lo, hi);
		case ($urandom_range(7))
			0: return lo - 1;
			1: return lo;
			2: return hi;
			3: return hi + 1;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	// Well-formed servo frames (all low, rise on a channel set, falls in up to
	// three groups) mixed with random level and timestamp noise.
	task automatic run_traffic(input int n_items);
		int start_cnt;
		logic [NCH-1:0] mask, lv;
		logic [TIME_W-1:0] rise_t, tmp;
		logic [TIME_W-1:0] w [3];
		int slot [NCH];
		start_cnt = events_sent;
		while (events_sent - start_cnt < n_items) begin
			if ($urandom_range(9) < 2) begin
				lv = NCH'($urandom_range(2**NCH - 1));
				if ($urandom_range(1))
					send_event(lv, $urandom());
				else
					send_event(lv, now_us + $urandom_range(3000));
			end else begin
				if (prev_levels != '0)
					send_event('0, now_us + pick_near(TIME_W'(wid_lo), TIME_W'(wid_hi)));
				mask = NCH'($urandom_range(2**NCH - 1, 1));
				rise_t = now_us + pick_near(TIME_W'(gap_lo), TIME_W'(gap_hi));
				send_event(mask, rise_t);
				for (int s = 0; s < 3; s++)
					w[s] = pick_near(TIME_W'(wid_lo), TIME_W'(wid_hi));
				for (int a = 0; a < 2; a++)
					for (int b = 0; b < 2 - a; b++)
						if (w[b] > w[b+1]) begin
							tmp = w[b];
							w[b] = w[b+1];
							w[b+1] = tmp;
						end
				for (int k = 0; k < NCH; k++)
					slot[k] = $urandom_range(2);
				lv = mask;
				for (int s = 0; s < 3; s++) begin
					for (int k = 0; k < NCH; k++)
						if (slot[k] == s)
							lv[k] = 1'b0;
					send_event(lv, rise_t + w[s]);
				end
			end
		end
	endtask

	task automatic test_directed_pulses();
		logic [TIME_W-1:0] wrap_t;
		wrap_t = 32'hFFFF_FC00;
		send_event(6'h01, 32'd15000);
		send_event(6'h00, 32'd16500);
		// First rise on channels 1-5 sees a gap too long to arm.
		send_event(6'h3F, 32'd36500);
		send_event(6'h00, 32'd38000);
		// All six armed and falling together gives the largest burst.
		send_event(6'h3F, 32'd58000);
		send_event(6'h00, 32'd59500);
		send_event(6'h00, 32'd60000);
		send_event(6'h3F, 32'd80000);
		send_event(6'h3E, 32'd80799);
		send_event(6'h3C, 32'd80800);
		send_event(6'h30, 32'd82200);
		send_event(6'h20, 32'd82201);
		send_event(6'h00, 32'd83000);
		send_event(6'h06, 32'd90800);
		send_event(6'h00, 32'd92000);
		send_event(6'h38, 32'd108201);
		send_event(6'h00, 32'd109201);
		// A pulse that straddles the timestamp wrap.
		send_event(6'h01, wrap_t - 32'd16000);
		send_event(6'h00, wrap_t - 32'd15000);
		send_event(6'h01, wrap_t);
		send_event(6'h00, wrap_t + 32'd1500);
		send_event(6'h3F, 32'hFFFF_FFFF);
	endtask

	task automatic test_window_extremes();
		// Width registers get upper bits set that must be dropped.
		set_windows(20'd0, 20'hFFFFF, 20'hF0000, 20'hFFFFF);
		send_event(6'h00, now_us + 32'd1);
		send_event(6'h3F, now_us);
		send_event(6'h00, now_us);
		run_traffic(15);
		// Inverted windows: nothing may arm or be accepted.
		set_windows(20'd5000, 20'd4000, 20'd900, 20'd800);
		run_traffic(12);
		set_windows(20'd12000, 20'd12000, 20'd1500, 20'd1500);
		run_traffic(12);
	endtask

	task automatic test_random_traffic();
		set_windows(GAP_MIN_RESET, GAP_MAX_RESET, CFG_W'(WIDTH_MIN_RESET),
			CFG_W'(WIDTH_MAX_RESET));
		src_idle_pct = 0;
		snk_stall_pct = 0;
		run_traffic(38);
		set_windows(20'd100, 20'd3000, 20'd10, 20'd500);
		src_idle_pct = 87;
		snk_stall_pct = 0;
		run_traffic(38);
		set_windows(20'd0, 20'd60000, 20'd0, 20'd65535);
		src_idle_pct = 0;
		snk_stall_pct = 87;
		run_traffic(38);
		set_windows(20'd5000, 20'd30000, 20'd900, 20'd2100);
		src_idle_pct = 29;
		snk_stall_pct = 29;
		run_traffic(38);
	endtask

	initial begin
		ev.valid <= 1'b0;
		ev.pin_levels <= '0;
		ev.timestamp_us <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAP_MIN;
		cfg_wdata <= '0;
		prev_levels = '0;
		for (int k = 0; k < NCH; k++) begin
			rise_at[k] = '0;
			fall_at[k] = '0;
			is_armed[k] = 1'b0;
		end
		gap_lo = GAP_MIN_RESET;
		gap_hi = GAP_MAX_RESET;
		wid_lo = WIDTH_MIN_RESET;
		wid_hi = WIDTH_MAX_RESET;
		now_us = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_pulses();
		test_window_extremes();
		test_random_traffic();
		wait_idle();

		$display("Sent %0d pin-change events across default, extreme, inverted and exact windows,",
			events_sent);
		$display("with four source/sink throttling mixes; %0d pulses checked, %0d errors.",
			pulses_seen, err_cnt);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
